FILE: sv/dense_id_pool_allocator_top_assert.svh
// Assertion macros used by the pool allocator core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DENSE_ID_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define DENSE_ID_POOL_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define DIPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DIPA_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define DIPA_ASSERT(lbl, prop, msg)
`define DIPA_ASSERT_NEXT(lbl, cond, conseq, msg)
`endif

`endif

FILE: sv/dipa_pkg.sv
package dipa_pkg;

    localparam int ID_COUNT = 256;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int CNT_W    = $clog2(ID_COUNT + 1);

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } status_t;

    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] id;
    } req_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        status_t          status;
        logic [CNT_W-1:0] in_use;
    } rsp_beat_t;

    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic [ID_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: sv/dense_id_pool_allocator_top.sv
// Identifier pool allocator kept as a dense list with a reverse position map.
// A full pool, an uncreated id and a fresh allocate answer straight from idle;
// a reused allocate or a free id reads the tables first; a release reads, then
// swaps. A request waits until the result enters the output beat; a release
// does two writes into each single-write-port table. Reset clears the state
// and counters only; tables need no clearing: only created entries are read.
module dense_id_pool_allocator_top
    import dipa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    mem_req_t        order_req, posn_req;
    logic [ID_W-1:0] order_rdata, posn_rdata;
    logic            res_valid, res_take;
    rsp_beat_t       res;
    logic            rsp_valid_reg;
    rsp_beat_t       rsp_reg;

    dipa_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_order (
        .clk   (clk),
        .we    (order_req.we),
        .waddr (order_req.waddr),
        .wdata (order_req.wdata),
        .raddr (order_req.raddr),
        .rdata (order_rdata)
    );

    dipa_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_posn (
        .clk   (clk),
        .we    (posn_req.we),
        .waddr (posn_req.waddr),
        .wdata (posn_req.wdata),
        .raddr (posn_req.raddr),
        .rdata (posn_rdata)
    );

    dipa_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .order_req   (order_req),
        .order_rdata (order_rdata),
        .posn_req    (posn_req),
        .posn_rdata  (posn_rdata),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    // load the output beat whenever the slot is empty or being drained
    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/dipa_ram.sv
module dipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/dipa_core.sv
`include "dense_id_pool_allocator_top_assert.svh"

module dipa_core
    import dipa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  req_beat_t       req,
    output mem_req_t        order_req,
    input  logic [ID_W-1:0] order_rdata,
    output mem_req_t        posn_req,
    input  logic [ID_W-1:0] posn_rdata,
    output logic            res_valid,
    input  logic            res_take,
    output rsp_beat_t       res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SWAP = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] created_reg, created_next;
    logic             act_reg, act_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [ID_W-1:0]  gid_reg, gid_next;
    status_t          status_reg, status_next;
    logic [CNT_W-1:0] last_pos;

    assign last_pos  = CNT_W'(used_reg - CNT_W'(1));
    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = '{granted_id: gid_reg, status: status_reg, in_use: used_reg};

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        created_next = created_reg;
        act_next     = act_reg;
        id_next      = id_reg;
        gid_next     = gid_reg;
        status_next  = status_reg;
        order_req    = '0;
        posn_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    id_next  = req.id;
                    if (req.action == ACT_ALLOC)
                    begin
                        if (used_reg == CNT_W'(ID_COUNT))
                        begin
                            gid_next    = '0;
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (used_reg >= created_reg)
                        begin
                            // create a fresh identifier at the end of the list
                            order_req.we    = 1'b1;
                            order_req.waddr = created_reg[ID_W-1:0];
                            order_req.wdata = created_reg[ID_W-1:0];
                            posn_req.we     = 1'b1;
                            posn_req.waddr  = created_reg[ID_W-1:0];
                            posn_req.wdata  = created_reg[ID_W-1:0];
                            gid_next        = created_reg[ID_W-1:0];
                            created_next    = CNT_W'(created_reg + CNT_W'(1));
                            used_next       = CNT_W'(used_reg + CNT_W'(1));
                            status_next     = ST_OK;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            order_req.raddr = used_reg[ID_W-1:0];
                            state_next      = S_READ;
                        end
                    end
                    else if ({1'b0, req.id} >= created_reg)
                    begin
                        gid_next    = req.id;
                        status_next = ST_NOT_USED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // fetch the position of the id and the last used entry
                        posn_req.raddr  = req.id;
                        order_req.raddr = last_pos[ID_W-1:0];
                        state_next      = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (act_reg == ACT_ALLOC)
                begin
                    gid_next    = order_rdata;
                    used_next   = CNT_W'(used_reg + CNT_W'(1));
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
                else if ({1'b0, posn_rdata} >= used_reg)
                begin
                    gid_next    = id_reg;
                    status_next = ST_NOT_USED;
                    state_next  = S_DONE;
                end
                else
                begin
                    // move the last used id into the freed slot
                    order_req.we    = 1'b1;
                    order_req.waddr = posn_rdata;
                    order_req.wdata = order_rdata;
                    posn_req.we     = 1'b1;
                    posn_req.waddr  = order_rdata;
                    posn_req.wdata  = posn_rdata;
                    state_next      = S_SWAP;
                end
            end
            S_SWAP:
            begin
                order_req.we    = 1'b1;
                order_req.waddr = last_pos[ID_W-1:0];
                order_req.wdata = id_reg;
                posn_req.we     = 1'b1;
                posn_req.waddr  = id_reg;
                posn_req.wdata  = last_pos[ID_W-1:0];
                used_next       = last_pos;
                gid_next        = id_reg;
                status_next     = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            created_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            created_reg <= created_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        id_reg     <= id_next;
        gid_reg    <= gid_next;
        status_reg <= status_next;
    end

    `DIPA_ASSERT(a_used_le_created, used_reg <= created_reg, "used count above created count")
    `DIPA_ASSERT(a_created_bound, created_reg <= CNT_W'(ID_COUNT), "created count out of range")
    `DIPA_ASSERT_NEXT(a_swap_shrinks, state_reg == S_SWAP, (state_reg == S_DONE) && (used_reg == CNT_W'($past(used_reg) - CNT_W'(1))), "release did not shrink pool")

endmodule
